// ===== rtl/core/vdh_pkg.sv =====
// shared types and constants for the voronoi distance heightmap core
package vdh_pkg;

	// field widths fixed by the interface
	localparam int COUNT_W    = 9;
	localparam int GAIN_W     = 15;
	localparam int GAIN_FRAC  = 12;
	localparam int FIELD_W    = 8;
	localparam int CFG_DATA_W = 15;

	localparam logic [FIELD_W-1:0] HEIGHT_MAX = 8'd255;

	// configuration register indexes
	typedef enum logic [0:0] {
		REG_SEED_COUNT    = 1'b0,
		REG_DISTANCE_GAIN = 1'b1
	} cfg_reg_t;

	// request kinds on the input tuser
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// control flags that travel with every beat down the chain
	typedef struct packed {
		logic vld;
		logic qry;
		logic have;
	} ctl_t;

endpackage

// ===== rtl/core/vdh_seed_cell.sv =====
// one seed cell: holds a seed point and folds it into the running nearest search
module vdh_seed_cell import vdh_pkg::*; #(
	parameter int CELL_IDX   = 0,
	parameter int COORD_BITS = 8,
	parameter int IDXW       = 8,
	parameter int CNTW       = 9
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic [CNTW-1:0]         count,
	input  ctl_t                    ctl_i,
	input  logic [COORD_BITS-1:0]   row_i,
	input  logic [COORD_BITS-1:0]   col_i,
	input  logic [FIELD_W-1:0]      ld_idx_i,
	input  logic [2*COORD_BITS:0]   best_sq_i,
	input  logic [IDXW-1:0]         best_idx_i,
	output ctl_t                    ctl_o,
	output logic [COORD_BITS-1:0]   row_o,
	output logic [COORD_BITS-1:0]   col_o,
	output logic [FIELD_W-1:0]      ld_idx_o,
	output logic [2*COORD_BITS:0]   best_sq_o,
	output logic [IDXW-1:0]         best_idx_o
);

	localparam int PW   = 2 * COORD_BITS;
	localparam int SQW  = 2 * COORD_BITS + 1;
	localparam int CMPW = (IDXW > FIELD_W) ? IDXW : FIELD_W;

	logic [COORD_BITS-1:0] seed_row_q, seed_col_q;
	logic [COORD_BITS-1:0] dr, dc;
	logic                  ld_hit;

	ctl_t                  ctl_s1, ctl_s2;
	logic [COORD_BITS-1:0] row_s1, col_s1, row_s2, col_s2;
	logic [FIELD_W-1:0]    ld_idx_s1, ld_idx_s2;
	logic [SQW-1:0]        best_sq_s1, best_sq_s2;
	logic [IDXW-1:0]       best_idx_s1, best_idx_s2;
	logic [PW-1:0]         dr2_s1, dc2_s1;

	logic [SQW-1:0]        sq;
	logic                  active, upd;

	assign dr = (row_i > seed_row_q) ? row_i - seed_row_q : seed_row_q - row_i;
	assign dc = (col_i > seed_col_q) ? col_i - seed_col_q : seed_col_q - col_i;

	// loads travel the chain too, so each cell sees them in beat order
	assign ld_hit = ctl_i.vld && (ctl_i.qry == REQ_LOAD)
		&& (CMPW'({{CMPW{1'b0}}, ld_idx_i}) == CMPW'(CELL_IDX));

	always_ff @(posedge clk) begin
		if (en && ld_hit) begin
			seed_row_q <= row_i;
			seed_col_q <= col_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= '{vld: ctl_s1.vld, qry: ctl_s1.qry, have: ctl_s1.have | upd};
		end
	end

	assign sq     = SQW'(dr2_s1) + SQW'(dc2_s1);
	assign active = (ctl_s1.qry == REQ_QUERY) && (CNTW'(CELL_IDX) < count);
	assign upd    = active && (!ctl_s1.have || (sq < best_sq_s1));

	always_ff @(posedge clk) begin
		if (en) begin
			row_s1      <= row_i;
			col_s1      <= col_i;
			ld_idx_s1   <= ld_idx_i;
			best_sq_s1  <= best_sq_i;
			best_idx_s1 <= best_idx_i;
			dr2_s1      <= PW'(dr) * PW'(dr);
			dc2_s1      <= PW'(dc) * PW'(dc);

			row_s2      <= row_s1;
			col_s2      <= col_s1;
			ld_idx_s2   <= ld_idx_s1;
			best_sq_s2  <= upd ? sq : best_sq_s1;
			best_idx_s2 <= upd ? IDXW'(CELL_IDX) : best_idx_s1;
		end
	end

	assign ctl_o      = ctl_s2;
	assign row_o      = row_s2;
	assign col_o      = col_s2;
	assign ld_idx_o   = ld_idx_s2;
	assign best_sq_o  = best_sq_s2;
	assign best_idx_o = best_idx_s2;

endmodule

// ===== rtl/core/vdh_sqrt_cell.sv =====
// one digit step of the pipelined floor square root
module vdh_sqrt_cell import vdh_pkg::*; #(
	parameter int RW   = 9,
	parameter int IDXW = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  ctl_t            ctl_i,
	input  logic [2*RW-1:0] rad_i,
	input  logic [RW+1:0]   rem_i,
	input  logic [RW-1:0]   root_i,
	input  logic [IDXW-1:0] idx_i,
	output ctl_t            ctl_o,
	output logic [2*RW-1:0] rad_o,
	output logic [RW+1:0]   rem_o,
	output logic [RW-1:0]   root_o,
	output logic [IDXW-1:0] idx_o
);

	ctl_t            ctl_s1;
	logic [2*RW-1:0] rad_s1;
	logic [RW+1:0]   rem_s1;
	logic [RW-1:0]   root_s1;
	logic [IDXW-1:0] idx_s1;

	logic [RW+1:0]   rem_sh, trial;
	logic            take;

	// bring down the next two radicand bits and try root*4+1
	assign rem_sh = {rem_i[RW-1:0], rad_i[2*RW-1 -: 2]};
	assign trial  = {root_i, 2'b01};
	assign take   = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s1  <= {rad_i[2*RW-3:0], 2'b00};
			rem_s1  <= take ? rem_sh - trial : rem_sh;
			root_s1 <= {root_i[RW-2:0], take};
			idx_s1  <= idx_i;
		end
	end

	assign ctl_o  = ctl_s1;
	assign rad_o  = rad_s1;
	assign rem_o  = rem_s1;
	assign root_o = root_s1;
	assign idx_o  = idx_s1;

endmodule

// ===== rtl/core/voronoi_distance_heightmap_core.sv =====
// cellular f1 height generator: seed cell chain, root pipeline and scaling
//
//  channel | direction | beat contents
//  s_*     | in        | tuser: req_type; tdata: seed_index, seed_row, seed_col, pixel_row, pixel_col
//  m_*     | out       | tuser: found; tdata: height, nearest_index
//  cfg_*   | in        | cfg_index selects seed_count or distance_gain, cfg_data is the value
//
// every beat, load or query, walks the seed cells in order, then RW root steps, one
// multiply stage and the output register, and a new beat may enter every cycle while
// the pipeline is not held. the whole pipeline holds while a result waits in the output
// register and m_tready is low. reset clears the stage valid flags, the output valid
// flag and the config registers; seed points are undefined until loaded.
module voronoi_distance_heightmap_core import vdh_pkg::*; #(
	parameter int MAX_SEEDS  = 256,
	parameter int COORD_BITS = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [39:0]           s_tdata,   // seed_index, seed_row, seed_col, pixel_row, pixel_col
	input  logic                  s_tuser,   // req_type

	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [15:0]           m_tdata,   // height, nearest_index
	output logic                  m_tuser,   // found

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [0:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int IDXW = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
	localparam int CNTW = (IDXW + 1 > COUNT_W) ? IDXW + 1 : COUNT_W;
	localparam int SQW  = 2 * COORD_BITS + 1;
	localparam int RW   = COORD_BITS + 1;
	localparam int PRW  = RW + GAIN_W;
	localparam int VW   = PRW - GAIN_FRAC;

	logic                en;

	logic [COUNT_W-1:0]  seed_count_q;
	logic [GAIN_W-1:0]   distance_gain_q;
	logic [CNTW-1:0]     count_ext;

	// config writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_count_q    <= '0;
			distance_gain_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_reg_t'(cfg_index))
				REG_SEED_COUNT:    seed_count_q    <= cfg_data[COUNT_W-1:0];
				REG_DISTANCE_GAIN: distance_gain_q <= cfg_data[GAIN_W-1:0];
				default: ;
			endcase
		end
	end

	assign count_ext = CNTW'({{CNTW{1'b0}}, seed_count_q});

	// entry of the chain
	logic                  qry_in;
	logic [FIELD_W-1:0]    row_sel, col_sel;
	ctl_t                  ctl_w      [0:MAX_SEEDS];
	logic [COORD_BITS-1:0] row_w      [0:MAX_SEEDS];
	logic [COORD_BITS-1:0] col_w      [0:MAX_SEEDS];
	logic [FIELD_W-1:0]    ld_idx_w   [0:MAX_SEEDS];
	logic [SQW-1:0]        best_sq_w  [0:MAX_SEEDS];
	logic [IDXW-1:0]       best_idx_w [0:MAX_SEEDS];

	assign s_tready = en;
	assign qry_in   = s_tuser;

	// a load rides the coordinate lanes with its seed point
	assign row_sel = (qry_in == REQ_QUERY) ? s_tdata[31:24] : s_tdata[15:8];
	assign col_sel = (qry_in == REQ_QUERY) ? s_tdata[39:32] : s_tdata[23:16];

	assign ctl_w[0]      = '{vld: s_tvalid, qry: qry_in, have: 1'b0};
	assign row_w[0]      = COORD_BITS'({{COORD_BITS{1'b0}}, row_sel});
	assign col_w[0]      = COORD_BITS'({{COORD_BITS{1'b0}}, col_sel});
	assign ld_idx_w[0]   = s_tdata[7:0];
	assign best_sq_w[0]  = '0;
	assign best_idx_w[0] = '0;

	for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
		vdh_seed_cell #(
			.CELL_IDX   (i),
			.COORD_BITS (COORD_BITS),
			.IDXW       (IDXW),
			.CNTW       (CNTW)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.en         (en),
			.count      (count_ext),
			.ctl_i      (ctl_w[i]),
			.row_i      (row_w[i]),
			.col_i      (col_w[i]),
			.ld_idx_i   (ld_idx_w[i]),
			.best_sq_i  (best_sq_w[i]),
			.best_idx_i (best_idx_w[i]),
			.ctl_o      (ctl_w[i+1]),
			.row_o      (row_w[i+1]),
			.col_o      (col_w[i+1]),
			.ld_idx_o   (ld_idx_w[i+1]),
			.best_sq_o  (best_sq_w[i+1]),
			.best_idx_o (best_idx_w[i+1])
		);
	end

	// floor square root, one result bit per step
	ctl_t            sq_ctl_w  [0:RW];
	logic [2*RW-1:0] sq_rad_w  [0:RW];
	logic [RW+1:0]   sq_rem_w  [0:RW];
	logic [RW-1:0]   sq_root_w [0:RW];
	logic [IDXW-1:0] sq_idx_w  [0:RW];

	assign sq_ctl_w[0]  = ctl_w[MAX_SEEDS];
	assign sq_rad_w[0]  = (2*RW)'(best_sq_w[MAX_SEEDS]);
	assign sq_rem_w[0]  = '0;
	assign sq_root_w[0] = '0;
	assign sq_idx_w[0]  = best_idx_w[MAX_SEEDS];

	for (genvar k = 0; k < RW; k++) begin : g_sqrt
		vdh_sqrt_cell #(
			.RW     (RW),
			.IDXW   (IDXW)
		) u_step (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.ctl_i  (sq_ctl_w[k]),
			.rad_i  (sq_rad_w[k]),
			.rem_i  (sq_rem_w[k]),
			.root_i (sq_root_w[k]),
			.idx_i  (sq_idx_w[k]),
			.ctl_o  (sq_ctl_w[k+1]),
			.rad_o  (sq_rad_w[k+1]),
			.rem_o  (sq_rem_w[k+1]),
			.root_o (sq_root_w[k+1]),
			.idx_o  (sq_idx_w[k+1])
		);
	end

	// gain multiply
	ctl_t            ctl_s1;
	logic [PRW-1:0]  prod_s1;
	logic [IDXW-1:0] idx_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (en) begin
			ctl_s1 <= sq_ctl_w[RW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= PRW'(sq_root_w[RW]) * PRW'(distance_gain_q);
			idx_s1  <= sq_idx_w[RW];
		end
	end

	// clamp and output register
	logic [VW-1:0]      value;
	logic [FIELD_W-1:0] height_d;
	logic               out_vld_q;
	logic [FIELD_W-1:0] height_q, nearest_q;
	logic               found_q;

	assign value    = prod_s1[PRW-1:GAIN_FRAC];
	assign height_d = (value >= VW'(HEIGHT_MAX)) ? '0 : FIELD_W'(VW'(HEIGHT_MAX) - value);

	assign en = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= ctl_s1.vld && (ctl_s1.qry == REQ_QUERY);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			found_q   <= ctl_s1.have;
			height_q  <= ctl_s1.have ? height_d : '0;
			nearest_q <= ctl_s1.have ? FIELD_W'({{FIELD_W{1'b0}}, idx_s1}) : '0;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {nearest_q, height_q};
	assign m_tuser  = found_q;

endmodule
